// ----- hw/rtl/b64sc_pkg.sv -----
package b64sc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SYM_W  = 7;
	localparam int unsigned BURST_N = 4;

	// symbol codes above the six-bit range
	localparam logic [SYM_W-1:0] SYM_BAD = 7'd64;
	localparam logic [SYM_W-1:0] SYM_PAD = 7'd65;

	localparam logic [BYTE_W-1:0] PAD_CHAR = 8'd61;

	// direction register values
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// one group of results waiting to leave
	typedef struct packed {
		logic [BURST_N-1:0][BYTE_W-1:0] data;
		logic [1:0]                     last_idx;
		logic                           err;
		logic                           mend;
	} burst_t;

	// six-bit value to alphabet character
	function automatic logic [BYTE_W-1:0] sym_to_char(input logic [5:0] v);
		logic [BYTE_W-1:0] c;
		if (v < 6'd26) begin
			c = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'd97 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'd48 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

	// alphabet character to six-bit value, pad or bad marker
	function automatic logic [SYM_W-1:0] char_to_sym(input logic [BYTE_W-1:0] c);
		logic [SYM_W-1:0] v;
		if (c >= 8'd65 && c <= 8'd90) begin
			v = 7'(c - 8'd65);
		end else if (c >= 8'd97 && c <= 8'd122) begin
			v = 7'(c - 8'd97 + 8'd26);
		end else if (c >= 8'd48 && c <= 8'd57) begin
			v = 7'(c - 8'd48 + 8'd52);
		end else if (c == 8'd43) begin
			v = 7'd62;
		end else if (c == 8'd47) begin
			v = 7'd63;
		end else if (c == PAD_CHAR) begin
			v = SYM_PAD;
		end else begin
			v = SYM_BAD;
		end
		return v;
	endfunction

endpackage

// ----- hw/rtl/base64_stream_codec_unit.sv -----
// Base64 codec (standard alphabet, '=' padding) on a byte stream. cfg_data
// selects encode (0) or decode (1); a write clears the group state, so write
// only between messages. Each request is folded into the group state in the
// cycle it is accepted; a request that completes a group (or ends the
// message, or hits a decode error) loads a burst of one to four results into
// the output register, which leave one per cycle while out_ready is high.
// Requests that give no result are taken every cycle, even while a burst
// drains; a request that gives results waits until the burst in the output
// register has gone. When the output never stalls, encoding therefore takes
// three bytes for every four results, and decoding one character per cycle.
// Decode errors give a single result with error set and out_byte zero; the
// rest of that message is dropped.
module base64_stream_codec_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [b64sc_pkg::BYTE_W-1:0] in_byte,
	input  logic                      last_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [b64sc_pkg::BYTE_W-1:0] out_byte,
	output logic                      run_last,
	output logic                      message_end,
	output logic                      error
);
	import b64sc_pkg::*;

	logic        dir_q;
	logic [23:0] group_bits_q;
	logic [1:0]  group_count_q;
	logic [1:0]  pad_count_q;
	logic        error_seen_q;

	burst_t      burst_q;
	logic        burst_valid_q;
	logic [1:0]  idx_q;

	logic [23:0] group_bits_d;
	logic [1:0]  group_count_d;
	logic [1:0]  pad_count_d;
	logic        error_seen_d;
	burst_t      burst_d;
	logic        emit;

	logic        accept;
	logic        drain_done;

	// encode helpers
	logic [23:0] enc_bits;
	logic [23:0] enc_aligned;
	logic [1:0]  enc_cnt;

	// decode helpers
	logic [SYM_W-1:0] sym;
	logic [5:0]  sym6;
	logic        bad;
	logic        is_pad;
	logic [23:0] dec_bits;
	logic [1:0]  dec_cnt;
	logic [1:0]  dec_pad;

	// output side
	assign out_valid   = burst_valid_q;
	assign out_byte    = burst_q.data[idx_q];
	assign run_last    = (idx_q == burst_q.last_idx);
	assign message_end = run_last & burst_q.mend;
	assign error       = burst_q.err;

	// requests without results pass while a burst drains
	assign drain_done = out_valid & out_ready & run_last;
	assign in_ready   = ~burst_valid_q | drain_done | ~emit;
	assign accept     = in_valid & in_ready;

	// shared decode of the incoming request
	assign enc_bits = {group_bits_q[15:0], in_byte};
	assign enc_cnt  = group_count_q + 2'd1;
	assign sym      = char_to_sym(in_byte);
	assign is_pad   = (sym == SYM_PAD);
	assign sym6     = is_pad ? 6'd0 : sym[5:0];
	assign bad      = (sym == SYM_BAD) || (is_pad && group_count_q < 2'd2) ||
	                  (!is_pad && pad_count_q != 2'd0);
	assign dec_bits = {group_bits_q[17:0], sym6};
	assign dec_cnt  = group_count_q + 2'd1;
	assign dec_pad  = is_pad ? pad_count_q + 2'd1 : pad_count_q;

	// left-align a short final encode group
	always_comb begin
		unique case (enc_cnt)
			2'd1:    enc_aligned = {enc_bits[7:0], 16'h0};
			2'd2:    enc_aligned = {enc_bits[15:0], 8'h0};
			default: enc_aligned = enc_bits;
		endcase
	end

	// next group state and result burst
	always_comb begin
		group_bits_d  = group_bits_q;
		group_count_d = group_count_q;
		pad_count_d   = pad_count_q;
		error_seen_d  = error_seen_q;
		emit          = 1'b0;
		burst_d.data     = '0;
		burst_d.last_idx = 2'd0;
		burst_d.err      = 1'b0;
		burst_d.mend     = last_in;

		if (dir_q == DIR_ENCODE) begin
			group_bits_d  = enc_bits;
			group_count_d = enc_cnt;
			if (enc_cnt == 2'd3 || last_in) begin
				emit = 1'b1;
				burst_d.last_idx = 2'd3;
				for (int i = 0; i < BURST_N; i++) begin
					if (i <= int'(enc_cnt)) begin
						burst_d.data[i] = sym_to_char(enc_aligned[23-6*i -: 6]);
					end else begin
						burst_d.data[i] = PAD_CHAR;
					end
				end
				group_bits_d  = '0;
				group_count_d = 2'd0;
			end
		end else if (error_seen_q) begin
			// message already flagged: drop until its end
			if (last_in) begin
				group_bits_d  = '0;
				group_count_d = 2'd0;
				pad_count_d   = 2'd0;
				error_seen_d  = 1'b0;
			end
		end else if (bad) begin
			emit        = 1'b1;
			burst_d.err = 1'b1;
			if (last_in) begin
				group_bits_d  = '0;
				group_count_d = 2'd0;
				pad_count_d   = 2'd0;
			end else begin
				error_seen_d = 1'b1;
			end
		end else begin
			group_bits_d  = dec_bits;
			group_count_d = dec_cnt;
			pad_count_d   = dec_pad;
			if (dec_cnt == 2'd0) begin
				// group of four complete: one to three bytes
				emit = 1'b1;
				burst_d.data[0] = dec_bits[23:16];
				burst_d.data[1] = dec_bits[15:8];
				burst_d.data[2] = dec_bits[7:0];
				burst_d.last_idx = (dec_pad >= 2'd2) ? 2'd0 :
				                   (dec_pad == 2'd1) ? 2'd1 : 2'd2;
				group_bits_d = '0;
			end else if (last_in) begin
				// message ends inside a group
				emit        = 1'b1;
				burst_d.err = 1'b1;
			end
			if (last_in) begin
				group_bits_d  = '0;
				group_count_d = 2'd0;
				pad_count_d   = 2'd0;
			end
		end
	end

	// direction and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q         <= DIR_ENCODE;
			group_bits_q  <= '0;
			group_count_q <= 2'd0;
			pad_count_q   <= 2'd0;
			error_seen_q  <= 1'b0;
		end else if (cfg_we) begin
			dir_q         <= cfg_data;
			group_bits_q  <= '0;
			group_count_q <= 2'd0;
			pad_count_q   <= 2'd0;
			error_seen_q  <= 1'b0;
		end else if (accept) begin
			group_bits_q  <= group_bits_d;
			group_count_q <= group_count_d;
			pad_count_q   <= pad_count_d;
			error_seen_q  <= error_seen_d;
		end
	end

	// burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			idx_q         <= 2'd0;
		end else if (accept && emit) begin
			burst_valid_q <= 1'b1;
			idx_q         <= 2'd0;
		end else if (drain_done) begin
			burst_valid_q <= 1'b0;
			idx_q         <= 2'd0;
		end else if (out_valid && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			burst_q <= burst_d;
		end
	end

endmodule
